>>> design/msfm_pkg.sv
// Package: widths, constants and the sequencer control store for the F-measure block.
`default_nettype none
package msfm_pkg;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned COUNT_W    = 21;
  localparam int unsigned Q_W        = 17;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned DEN_W      = COUNT_W + 2;
  localparam int unsigned CNT_W      = 5;
  localparam int unsigned PC_W       = 3;
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 120;

  localparam logic [PIX_W-1:0]   PIX_OBJECT  = 8'd0;
  localparam logic [PIX_W-1:0]   PIX_BACK    = 8'd255;
  localparam logic [PIX_W-1:0]   MASK_ON     = 8'd255;
  localparam longint unsigned    MAX_PIXELS  = 1048576;
  localparam longint unsigned    COUNT_MAX   = (64'd1 << COUNT_W) - 64'd1;
  localparam logic [COUNT_W-1:0] COUNT_CAP   =
    (MAX_PIXELS > COUNT_MAX) ? COUNT_W'(COUNT_MAX) : COUNT_W'(MAX_PIXELS);
  localparam logic [Q_W-1:0]     THRESH_RESET = 17'd33423;
  localparam logic [Q_W-1:0]     Q_ONE        = 17'd65536;

  typedef enum logic [1:0] {
    DEN_PREC = 2'd0,
    DEN_REC  = 2'd1,
    DEN_F    = 2'd2
  } den_e;

  typedef enum logic [1:0] {
    DST_NONE = 2'd0,
    DST_PREC = 2'd1,
    DST_REC  = 2'd2,
    DST_OUT  = 2'd3
  } dst_e;

  typedef enum logic [1:0] {
    COND_TRUE = 2'd0,
    COND_LAST = 2'd1,
    COND_DONE = 2'd2,
    COND_OUT  = 2'd3
  } cond_e;

  typedef struct packed {
    logic            acc;
    logic            load;
    logic            shift;
    den_e            den;
    dst_e            dst;
    cond_e           cond;
    logic [PC_W-1:0] target;
  } ucode_t;

  localparam logic [PC_W-1:0] PC_ACC  = 3'd0;
  localparam logic [PC_W-1:0] PC_LDP  = 3'd1;
  localparam logic [PC_W-1:0] PC_DIVP = 3'd2;
  localparam logic [PC_W-1:0] PC_LDR  = 3'd3;
  localparam logic [PC_W-1:0] PC_DIVR = 3'd4;
  localparam logic [PC_W-1:0] PC_LDF  = 3'd5;
  localparam logic [PC_W-1:0] PC_DIVF = 3'd6;
  localparam logic [PC_W-1:0] PC_OUT  = 3'd7;

  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    w = '{acc: 1'b0, load: 1'b0, shift: 1'b0, den: DEN_PREC, dst: DST_NONE,
          cond: COND_TRUE, target: PC_ACC};
    unique case (pc)
      PC_ACC: begin
        w.acc = 1'b1; w.cond = COND_LAST; w.target = PC_LDP;
      end
      PC_LDP: begin
        w.load = 1'b1; w.den = DEN_PREC; w.target = PC_DIVP;
      end
      PC_DIVP: begin
        w.shift = 1'b1; w.cond = COND_DONE; w.target = PC_LDR;
      end
      PC_LDR: begin
        w.load = 1'b1; w.den = DEN_REC; w.dst = DST_PREC; w.target = PC_DIVR;
      end
      PC_DIVR: begin
        w.shift = 1'b1; w.cond = COND_DONE; w.target = PC_LDF;
      end
      PC_LDF: begin
        w.load = 1'b1; w.den = DEN_F; w.dst = DST_REC; w.target = PC_DIVF;
      end
      PC_DIVF: begin
        w.shift = 1'b1; w.cond = COND_DONE; w.target = PC_OUT;
      end
      PC_OUT: begin
        w.dst = DST_OUT; w.cond = COND_OUT; w.target = PC_ACC;
      end
      default: begin
        w.target = PC_ACC;
      end
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

>>> design/masked_segmentation_f_measure_top.sv
// Masked F-measure over a pixel stream: pixel counters, microcoded divider sequencer, result register.
//
// Input stream (s_axis): one pixel per transfer, mask/truth/predicted in tdata,
// tlast marks the final pixel of an image. Pixels are taken one per cycle while
// the sequencer sits in its accumulate step.
// Output stream (m_axis): one result per image, counts (a zero count is reported as 1),
// precision, recall, F-value (Q0.16) and the pass flag, held in an output register until taken.
// Configuration: cfg_we_i writes cfg_wdata_i into the pass threshold.
// Sequence: after the last pixel the sequencer runs three 16/16/17-step
// restoring divisions on one shared subtractor, plus load and store steps;
// the result is valid in the cycle after the output step loads it. s_axis_tready
// stays low until the sequencer is back in its accumulate step.
// Stall: if the previous result has not been taken, the sequencer holds at its
// output step and input stays blocked until the output register frees.
// Reset: counters clear, threshold returns to 33423, no result pending.
`default_nettype none
module masked_segmentation_f_measure_top (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tvalid,
  output      logic                               s_axis_tready,
  // [7:0] mask_pixel, [15:8] truth_pixel, [23:16] predicted_pixel
  input  wire logic [msfm_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  input  wire logic                               s_axis_tlast,
  output      logic                               m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // [20:0] true_positives, [41:21] false_positives, [62:42] false_negatives,
  // [79:63] precision_q16, [96:80] recall_q16, [113:97] f_value_q16,
  // [114] passes, [119:115] zero
  output      logic [msfm_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  input  wire logic                               cfg_we_i,
  input  wire logic [msfm_pkg::Q_W-1:0]           cfg_wdata_i
);
  import msfm_pkg::*;

  logic [PC_W-1:0]    pc_q, pc_d;
  ucode_t             uc;
  logic               cond_ok;

  logic [Q_W-1:0]     thr_q;
  logic [COUNT_W-1:0] tp_q, fp_q, fn_q, tp_d, fp_d, fn_d;
  logic [COUNT_W-1:0] tp_s_q, fp_s_q, fn_s_q;
  logic [PIX_W-1:0]   mask_px, truth_px, pred_px;
  logic               in_xfer, hit_tp, hit_fp, hit_fn;

  logic [DEN_W-1:0]   den_q, den_sel, rem_q;
  logic [DEN_W:0]     rem2, diff;
  logic               ge;
  logic [Q_W-1:0]     quo_q;
  logic [CNT_W-1:0]   cnt_q;

  logic [Q_W-1:0]     prec_q, rec_q;
  logic               out_valid_q, out_free, out_load;
  logic [COUNT_W-1:0] out_tp_q, out_fp_q, out_fn_q;
  logic [Q_W-1:0]     out_prec_q, out_rec_q, out_f_q;
  logic               out_pass_q;

  assign uc = ucode_rom(pc_q);

  assign mask_px  = s_axis_tdata[7:0];
  assign truth_px = s_axis_tdata[15:8];
  assign pred_px  = s_axis_tdata[23:16];

  assign s_axis_tready = uc.acc;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  assign hit_tp = (mask_px == MASK_ON) && (truth_px == PIX_OBJECT) && (pred_px == PIX_OBJECT);
  assign hit_fp = (mask_px == MASK_ON) && (truth_px == PIX_BACK) && (pred_px == PIX_OBJECT);
  assign hit_fn = (mask_px == MASK_ON) && (truth_px == PIX_OBJECT) && (pred_px == PIX_BACK);

  always_comb begin
    tp_d = tp_q;
    fp_d = fp_q;
    fn_d = fn_q;
    if (in_xfer && hit_tp && (tp_q < COUNT_CAP)) tp_d = tp_q + COUNT_W'(1);
    if (in_xfer && hit_fp && (fp_q < COUNT_CAP)) fp_d = fp_q + COUNT_W'(1);
    if (in_xfer && hit_fn && (fn_q < COUNT_CAP)) fn_d = fn_q + COUNT_W'(1);
  end

  assign out_free = !out_valid_q || m_axis_tready;
  assign out_load = (uc.dst == DST_OUT) && out_free;

  always_comb begin
    unique case (uc.cond)
      COND_TRUE: cond_ok = 1'b1;
      COND_LAST: cond_ok = in_xfer && s_axis_tlast;
      COND_DONE: cond_ok = (cnt_q == CNT_W'(1));
      COND_OUT:  cond_ok = out_free;
      default:   cond_ok = 1'b0;
    endcase
    pc_d = cond_ok ? uc.target : pc_q;
  end

  always_comb begin
    unique case (uc.den)
      DEN_PREC: den_sel = DEN_W'(tp_s_q) + DEN_W'(fp_s_q);
      DEN_REC:  den_sel = DEN_W'(tp_s_q) + DEN_W'(fn_s_q);
      DEN_F:    den_sel = DEN_W'({tp_s_q, 1'b0}) + DEN_W'(fp_s_q) + DEN_W'(fn_s_q);
      default:  den_sel = '0;
    endcase
  end

  assign rem2 = {rem_q, 1'b0};
  assign diff = rem2 - {1'b0, den_q};
  assign ge   = (rem2 >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= PC_ACC;
      thr_q       <= THRESH_RESET;
      tp_q        <= '0;
      fp_q        <= '0;
      fn_q        <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pc_q <= pc_d;
      if (cfg_we_i) thr_q <= cfg_wdata_i;
      if (in_xfer && s_axis_tlast) begin
        tp_q <= '0;
        fp_q <= '0;
        fn_q <= '0;
      end else begin
        tp_q <= tp_d;
        fp_q <= fp_d;
        fn_q <= fn_d;
      end
      if (uc.load) begin
        cnt_q <= (uc.den == DEN_F) ? CNT_W'(Q_W) : CNT_W'(FRAC_W);
      end else if (uc.shift) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && s_axis_tlast) begin
      tp_s_q <= (tp_d == '0) ? COUNT_W'(1) : tp_d;
      fp_s_q <= (fp_d == '0) ? COUNT_W'(1) : fp_d;
      fn_s_q <= (fn_d == '0) ? COUNT_W'(1) : fn_d;
    end
    if (uc.dst == DST_PREC) prec_q <= quo_q;
    if (uc.dst == DST_REC)  rec_q  <= quo_q;
    if (uc.load) begin
      den_q <= den_sel;
      rem_q <= DEN_W'(tp_s_q);
      quo_q <= '0;
    end else if (uc.shift) begin
      rem_q <= ge ? diff[DEN_W-1:0] : rem2[DEN_W-1:0];
      quo_q <= {quo_q[Q_W-2:0], ge};
    end
    if (out_load) begin
      out_tp_q   <= tp_s_q;
      out_fp_q   <= fp_s_q;
      out_fn_q   <= fn_s_q;
      out_prec_q <= prec_q;
      out_rec_q  <= rec_q;
      out_f_q    <= quo_q;
      out_pass_q <= (quo_q >= thr_q);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_pass_q, out_f_q, out_rec_q, out_prec_q,
                          out_fn_q, out_fp_q, out_tp_q};

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && s_axis_tlast) |=> (tp_q == '0 && fp_q == '0 && fn_q == '0))
    else $error("counters not cleared after last pixel");

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    uc.shift |-> (cnt_q != '0))
    else $error("divider step with exhausted count");

  a_q16_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_prec_q < Q_ONE && out_rec_q < Q_ONE && out_f_q <= Q_ONE))
    else $error("quotient out of Q0.16 range");

  a_no_input_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && s_axis_tlast) |=> !s_axis_tready)
    else $error("input taken while sequencer busy");

endmodule
`default_nettype wire
